>>> hdl/haversine_distance_defines.svh
// Assertion macros for the haversine distance block.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define HVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine_distance: implication check failed");
`define HVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haversine_distance: next-cycle check failed");
`else
`define HVD_ASSERT_IMP(label, ante, cons)
`define HVD_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hdl/hvd_pkg.sv
package hvd_pkg;

    localparam int CORDIC_STAGES_DEF = 28;
    localparam int TABLE_LEN = 64;

    localparam logic [63:0] Q_ONE = 64'h1000_0000_0000_0000;

    localparam logic signed [33:0] DEG_QUARTER = 34'sd754974720;
    localparam logic signed [33:0] DEG_HALF    = 34'sd1509949440;
    localparam logic signed [33:0] DEG_TURN    = 34'sd3019898880;

    localparam logic [30:0] RADIUS_X100_RESET = 31'd637100000;

    typedef logic [TABLE_LEN-1:0][63:0] atan_tab_t;

    typedef struct packed {
        logic [63:0] hh;
        logic [63:0] hl;
        logic [63:0] lh;
        logic [63:0] ll;
    } pp_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [60:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic               tag;
    } cord_t;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_shr_c(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] atan_recip_q62(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] nn;
        p   = udiv64(64'h4000_0000_0000_0000, n);
        sum = '0;
        nn  = n * n;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 0)
            begin
                t = udiv64(p, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - t;
                else
                    sum = sum + t;
                p = udiv64(p, nn);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_pow2_q62(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        p   = 64'h4000_0000_0000_0000 >> i;
        sum = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 0)
            begin
                t = udiv64(p, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - t;
                else
                    sum = sum + t;
                p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi_q62();
        return (atan_recip_q62(64'd5) << 2) - atan_recip_q62(64'd239);
    endfunction

    function automatic atan_tab_t atan_table();
        atan_tab_t tab;
        tab[0] = (quarter_pi_q62() + 64'd2) >> 2;
        for (int i = 1; i < TABLE_LEN; i++)
            tab[i] = (atan_pow2_q62(i) + 64'd2) >> 2;
        return tab;
    endfunction

    // inverse CORDIC gain, Newton on 1/sqrt(prod)
    function automatic logic [63:0] gain_inv_q60(input int n);
        logic [63:0] prod;
        logic [63:0] y;
        logic [63:0] py;
        logic [63:0] f;
        logic [63:0] three;
        prod  = Q_ONE;
        three = 64'd3 << 60;
        for (int i = 0; i < TABLE_LEN; i++)
            if (i < n && 2 * i < 64)
                prod = prod + (prod >> (2 * i));
        y = 64'd3 << 58;
        for (int j = 0; j < 12; j++)
        begin
            py = mul_shr_c(prod, mul_shr_c(y, y, 60), 60);
            f  = (three > py) ? three - py : 64'd0;
            y  = mul_shr_c(y, f, 61);
        end
        return y;
    endfunction

    localparam atan_tab_t   ATAN_Q60 = atan_table();
    localparam logic [63:0] RAD_Q62  = udiv64(quarter_pi_q62(), 64'd45);

    // four 32x32 partial products
    function automatic pp_t pp_make(input logic [63:0] a, input logic [63:0] b);
        pp_t p;
        p.hh = a[63:32] * b[63:32];
        p.hl = a[63:32] * b[31:0];
        p.lh = a[31:0] * b[63:32];
        p.ll = a[31:0] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] pp_join(input pp_t p, input int sh);
        logic [127:0] s;
        s = {p.hh, 64'b0} + {32'b0, p.hl, 32'b0} + {32'b0, p.lh, 32'b0} + {64'b0, p.ll};
        s = s >> sh;
        return s[63:0];
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // one digit of the restoring square root
    function automatic sq_t sqrt_step(input logic [63:0] rem, input logic [60:0] root,
                                      input logic [1:0] pair);
        logic [63:0] r2;
        logic [63:0] t;
        sq_t o;
        r2 = {rem[61:0], pair};
        t  = {1'b0, root, 2'b01};
        if (r2 >= t)
        begin
            o.rem  = r2 - t;
            o.root = {root[59:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {root[59:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> hdl/haversine_distance.sv
// Haversine great-circle distance, one request per clock while not stalled.
// Request channel: in_valid/in_ready with two points, latitude and longitude in
// 2^-22 degree units. Result channel: out_valid/out_ready with distance_cm,
// the distance in whole centimetres rounded to nearest.
// Sphere radius: cfg_we writes sphere_radius_m (metres); write it only while
// no request is in flight. It takes effect on the next request.
// Throughput: one request per cycle while the pipeline is not stalled.
// The latency is set by two CORDIC pipelines (sine/cosine, then atan2) and
// the 61-digit pipelined square root between them.
// Reset: all pipeline valids clear, radius returns to 6371000 m.
// Stall: while out_valid is high and out_ready low the whole pipeline
// holds; in_ready drops in the same cycle and nothing is lost or repeated.
`include "haversine_distance_defines.svh"

module haversine_distance import hvd_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic        [23:0] sphere_radius_m,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [29:0] first_latitude,
    input  logic signed [30:0] first_longitude,
    input  logic signed [29:0] second_latitude,
    input  logic signed [30:0] second_longitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [31:0] distance_cm
);

    localparam logic [63:0] GAIN_INV = gain_inv_q60(CORDIC_STAGES);

    logic        adv;
    logic [30:0] rad100_reg;

    logic [4:0]  f_valid_reg;
    logic [4:0]  m_valid_reg;
    logic [61:0] sq_valid_reg;
    logic [2:0]  z_valid_reg;
    logic        out_valid_reg;
    logic [31:0] dist_reg;

    // angle front end, four lanes: dlat, dlon, 2*lat1, 2*lat2
    logic signed [33:0] d_next [4];
    logic signed [33:0] d_reg [4];
    logic signed [33:0] m_reg [4];
    logic [29:0]        fmag_reg [4];
    logic [3:0]         fneg_reg;
    logic [3:0]         fflip_reg;
    pp_t                fpp_reg [4];
    logic [3:0]         pneg_reg;
    logic [3:0]         pflip_reg;
    cord_t              cin_reg [4];
    cord_t              co [4];
    logic [3:0]         co_valid;

    // haversine term
    logic [63:0] sl_reg, sn_reg, c1a_reg, c2a_reg;
    logic        opp0_reg, opp1_reg, opp2_reg, opp3_reg, opp4_reg;
    pp_t         pp1_reg [3];
    logic [63:0] t1_2_reg, cc_reg, ss2_reg;
    pp_t         pp3_reg;
    logic [63:0] t1_3_reg, t1_4_reg, t2_reg;
    logic        c1_neg, c2_neg;
    logic signed [64:0] sum_a;
    logic [60:0] a_cl;

    // square roots
    logic [61:0] src_a_reg [0:30];
    logic [61:0] src_b_reg [0:30];
    sq_t         sq_a_reg [1:61];
    sq_t         sq_b_reg [1:61];

    // atan2 and scaling
    cord_t       vin;
    cord_t       vo;
    logic        vo_valid;
    logic [63:0] zc_reg;
    pp_t         zpp_reg;
    logic [63:0] draw_reg;
    logic [64:0] rounded;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign distance_cm = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rad100_reg <= RADIUS_X100_RESET;
        else if (cfg_we)
            rad100_reg <= 31'(sphere_radius_m) * 31'd100;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= '0;
            m_valid_reg   <= '0;
            sq_valid_reg  <= '0;
            z_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg   <= {f_valid_reg[3:0], in_valid};
            m_valid_reg   <= {m_valid_reg[3:0], &co_valid};
            sq_valid_reg  <= {sq_valid_reg[60:0], m_valid_reg[4]};
            z_valid_reg   <= {z_valid_reg[1:0], vo_valid};
            out_valid_reg <= z_valid_reg[2];
        end
    end

    assign d_next[0] = 34'(second_latitude) - 34'(first_latitude);
    assign d_next[1] = 34'(second_longitude) - 34'(first_longitude);
    assign d_next[2] = 34'(first_latitude) <<< 1;
    assign d_next[3] = 34'(second_latitude) <<< 1;

    genvar l;
    generate
        for (l = 0; l < 4; l++)
        begin : g_lane
            logic signed [33:0] m_next;
            logic signed [33:0] fold;
            logic               flip;
            logic [63:0]        mag;
            cord_t              cin_next;

            // reduce to [-180, 180)
            always_comb
            begin
                priority if (d_reg[l] >= DEG_HALF)
                    m_next = d_reg[l] - DEG_TURN;
                else if (d_reg[l] < -DEG_HALF)
                    m_next = d_reg[l] + DEG_TURN;
                else
                    m_next = d_reg[l];
            end

            // fold into [-90, 90]
            always_comb
            begin
                flip = 1'b1;
                priority if (m_reg[l] > DEG_QUARTER)
                    fold = DEG_HALF - m_reg[l];
                else if (m_reg[l] < -DEG_QUARTER)
                    fold = -DEG_HALF - m_reg[l];
                else
                begin
                    fold = m_reg[l];
                    flip = 1'b0;
                end
            end

            always_comb
            begin
                mag        = pp_join(fpp_reg[l], 25);
                cin_next.x = $signed(GAIN_INV);
                cin_next.y = '0;
                cin_next.z = pneg_reg[l] ? -$signed(mag) : $signed(mag);
                cin_next.tag = pflip_reg[l];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_reg[l]     <= d_next[l];
                    m_reg[l]     <= m_next;
                    fmag_reg[l]  <= (fold < 0) ? 30'(-fold) : 30'(fold);
                    fneg_reg[l]  <= (fold < 0);
                    fflip_reg[l] <= flip;
                    fpp_reg[l]   <= pp_make(64'(fmag_reg[l]), RAD_Q62);
                    pneg_reg[l]  <= fneg_reg[l];
                    pflip_reg[l] <= fflip_reg[l];
                    cin_reg[l]   <= cin_next;
                end
            end

            hvd_cordic #(
                .STAGES    (CORDIC_STAGES),
                .VECTORING (1'b0)
            ) u_sincos (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (f_valid_reg[4]),
                .in_data   (cin_reg[l]),
                .out_valid (co_valid[l]),
                .out_data  (co[l])
            );
        end
    endgenerate

    // cosine sign: x negated when the angle was folded
    assign c1_neg = co[2].tag ? (co[2].x > 0) : (co[2].x < 0);
    assign c2_neg = co[3].tag ? (co[3].x > 0) : (co[3].x < 0);

    always_comb
    begin
        sum_a = opp4_reg ? $signed({1'b0, t1_4_reg}) - $signed({1'b0, t2_reg})
                         : $signed({1'b0, t1_4_reg}) + $signed({1'b0, t2_reg});
        priority if (sum_a < 0)
            a_cl = '0;
        else if (sum_a > $signed({1'b0, Q_ONE}))
            a_cl = Q_ONE[60:0];
        else
            a_cl = sum_a[60:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_reg     <= abs64(co[0].y);
            sn_reg     <= abs64(co[1].y);
            c1a_reg    <= abs64(co[2].x);
            c2a_reg    <= abs64(co[3].x);
            opp0_reg   <= c1_neg != c2_neg;
            pp1_reg[0] <= pp_make(sl_reg, sl_reg);
            pp1_reg[1] <= pp_make(c1a_reg, c2a_reg);
            pp1_reg[2] <= pp_make(sn_reg, sn_reg);
            opp1_reg   <= opp0_reg;
            t1_2_reg   <= pp_join(pp1_reg[0], 60);
            cc_reg     <= pp_join(pp1_reg[1], 60);
            ss2_reg    <= pp_join(pp1_reg[2], 60);
            opp2_reg   <= opp1_reg;
            pp3_reg    <= pp_make(cc_reg, ss2_reg);
            t1_3_reg   <= t1_2_reg;
            opp3_reg   <= opp2_reg;
            t2_reg     <= pp_join(pp3_reg, 60);
            t1_4_reg   <= t1_3_reg;
            opp4_reg   <= opp3_reg;
            src_a_reg[0] <= {1'b0, a_cl};
            src_b_reg[0] <= {1'b0, Q_ONE[60:0] - a_cl};
        end
    end

    // sqrt(a) and sqrt(1-a), one result bit per stage
    genvar s;
    generate
        for (s = 0; s < 61; s++)
        begin : g_sqrt
            sq_t        cur_a;
            sq_t        cur_b;
            logic [1:0] pr_a;
            logic [1:0] pr_b;

            if (s == 0)
            begin : g_first
                assign cur_a = '0;
                assign cur_b = '0;
            end
            else
            begin : g_next
                assign cur_a = sq_a_reg[s];
                assign cur_b = sq_b_reg[s];
            end

            if (s <= 30)
            begin : g_pair
                assign pr_a = src_a_reg[s][2*(30-s) +: 2];
                assign pr_b = src_b_reg[s][2*(30-s) +: 2];
            end
            else
            begin : g_zero
                assign pr_a = 2'b00;
                assign pr_b = 2'b00;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_a_reg[s+1] <= sqrt_step(cur_a.rem, cur_a.root, pr_a);
                    sq_b_reg[s+1] <= sqrt_step(cur_b.rem, cur_b.root, pr_b);
                end
            end

            if (s < 30)
            begin : g_src
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        src_a_reg[s+1] <= src_a_reg[s];
                        src_b_reg[s+1] <= src_b_reg[s];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        vin.x   = $signed({3'b000, sq_b_reg[61].root});
        vin.y   = $signed({3'b000, sq_a_reg[61].root});
        vin.z   = '0;
        vin.tag = 1'b0;
    end

    hvd_cordic #(
        .STAGES    (CORDIC_STAGES),
        .VECTORING (1'b1)
    ) u_atan2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid_reg[61]),
        .in_data   (vin),
        .out_valid (vo_valid),
        .out_data  (vo)
    );

    assign rounded = ({1'b0, draw_reg} + 65'd1) >> 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zc_reg   <= (vo.z < 0) ? 64'd0 : 64'(vo.z);
            zpp_reg  <= pp_make(zc_reg, 64'(rad100_reg));
            draw_reg <= pp_join(zpp_reg, 58);
            dist_reg <= (rounded > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
        end
    end

    `HVD_ASSERT_NXT(a_front_hold, !adv && f_valid_reg[0], f_valid_reg[0] && $stable(d_reg[0]))
    `HVD_ASSERT_IMP(a_root_range, sq_valid_reg[61], sq_a_reg[61].root <= Q_ONE[60:0] && sq_b_reg[61].root <= Q_ONE[60:0])
    `HVD_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(z_valid_reg[2]) && $past(adv))

endmodule

>>> hdl/hvd_cordic.sv
module hvd_cordic import hvd_pkg::*; #(
    parameter int STAGES    = CORDIC_STAGES_DEF,
    parameter bit VECTORING = 1'b0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_data,
    output logic  out_valid,
    output cord_t out_data
);

    logic [STAGES-1:0] valid_reg;
    cord_t             stage_reg [STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            cord_t              cur;
            cord_t              stage_next;
            logic signed [63:0] dx;
            logic signed [63:0] dy;
            logic signed [63:0] da;
            logic               pos;

            if (i == 0)
            begin : g_head
                assign cur = in_data;
            end
            else
            begin : g_body
                assign cur = stage_reg[i-1];
            end

            always_comb
            begin
                dx  = $signed(cur.y) >>> i;
                dy  = $signed(cur.x) >>> i;
                da  = $signed(ATAN_Q60[i]);
                pos = VECTORING ? ($signed(cur.y) >= 0) : ($signed(cur.z) >= 0);
                stage_next     = cur;
                if (VECTORING == pos)
                begin
                    // vectoring with y >= 0, or rotation with z < 0
                    stage_next.x = cur.x + dx;
                    stage_next.y = cur.y - dy;
                    stage_next.z = cur.z + da;
                end
                else
                begin
                    stage_next.x = cur.x - dx;
                    stage_next.y = cur.y + dy;
                    stage_next.z = cur.z - da;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[i] <= stage_next;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = stage_reg[STAGES-1];

endmodule

>>> dv/haversine_distance_checker.sv
`timescale 1ns / 1ps

module haversine_distance_checker #(
    parameter int STAGES = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic        [23:0] sphere_radius_m,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [29:0] first_latitude,
    input  logic signed [30:0] first_longitude,
    input  logic signed [29:0] second_latitude,
    input  logic signed [30:0] second_longitude,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic        [31:0] distance_cm,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam longint QUARTER = 64'sd754974720;
    localparam longint TURN    = 64'sd3019898880;
    localparam logic [63:0] UNITY = 64'h1000_0000_0000_0000;

    longint      arctan_q60 [64];
    logic [63:0] rad_per_unit;
    longint      inv_gain;
    logic [23:0] radius_m;
    logic [31:0] distance_due [$];

    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] arctan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        p   = (64'd1 << 62) / n;
        sum = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0])
                sum = sum - p / (2 * k + 1);
            else
                sum = sum + p / (2 * k + 1);
            p = p / (n * n);
            k++;
        end
        return sum;
    endfunction

    function automatic logic [63:0] arctan_pow2(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        p   = (64'd1 << 62) >> i;
        sum = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0])
                sum = sum - p / (2 * k + 1);
            else
                sum = sum + p / (2 * k + 1);
            p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
            k++;
        end
        return sum;
    endfunction

    initial
    begin
        logic [63:0] qpi;
        logic [63:0] prod;
        logic [63:0] y;
        logic [63:0] py;
        logic [63:0] f;
        qpi = 4 * arctan_recip(5) - arctan_recip(239);
        arctan_q60[0] = longint'((qpi + 2) >> 2);
        for (int i = 1; i < 64; i++)
            arctan_q60[i] = longint'((arctan_pow2(i) + 2) >> 2);
        rad_per_unit = qpi / 45;
        prod = UNITY;
        for (int i = 0; i < STAGES; i++)
            if (2 * i < 64)
                prod = prod + (prod >> (2 * i));
        y = 64'd3 << 58;
        for (int j = 0; j < 12; j++)
        begin
            py = scaled_product(prod, scaled_product(y, y, 60), 60);
            f  = ((64'd3 << 60) > py) ? (64'd3 << 60) - py : 64'd0;
            y  = scaled_product(y, f, 61);
        end
        inv_gain = longint'(y);
    end

    // sine and cosine (Q60) of an angle in 2^-23 degree units
    task automatic rotate_angle(input longint u, output longint s, output longint c);
        longint m;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [63:0] mag;
        bit flip;
        flip = 0;
        m = u % TURN;
        if (m < 0)
            m += TURN;
        if (m >= TURN / 2)
            m -= TURN;
        if (m > QUARTER)
        begin
            m = 2 * QUARTER - m;
            flip = 1;
        end
        else if (m < -QUARTER)
        begin
            m = -2 * QUARTER - m;
            flip = 1;
        end
        mag = scaled_product(64'(m < 0 ? -m : m), rad_per_unit, 25);
        z = (m < 0) ? -longint'(mag) : longint'(mag);
        x = inv_gain;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_q60[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_q60[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] root_q60(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] pair;
        r = 0;
        q = 0;
        for (int k = 60; k >= 0; k--)
        begin
            pair = (k >= 30) ? ((a >> (2 * k - 60)) & 64'd3) : 64'd0;
            r = (r << 2) | pair;
            t = (q << 2) | 64'd1;
            if (r >= t)
            begin
                r -= t;
                q = (q << 1) | 64'd1;
            end
            else
                q = q << 1;
        end
        return q;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    task automatic predict_distance(input longint lat1, input longint lon1, input longint lat2,
                                    input longint lon2, input logic [23:0] rad,
                                    output logic [31:0] want_cm);
        longint s_lat;
        longint s_lon;
        longint c1;
        longint c2;
        longint unused;
        longint hav;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] d;
        rotate_angle(lat2 - lat1, s_lat, unused);
        rotate_angle(lon2 - lon1, s_lon, unused);
        rotate_angle(2 * lat1, unused, c1);
        rotate_angle(2 * lat2, unused, c2);
        t1 = scaled_product(magnitude(s_lat), magnitude(s_lat), 60);
        t2 = scaled_product(scaled_product(magnitude(c1), magnitude(c2), 60),
                            scaled_product(magnitude(s_lon), magnitude(s_lon), 60), 60);
        if ((c1 < 0) != (c2 < 0))
            hav = longint'(t1) - longint'(t2);
        else
            hav = longint'(t1) + longint'(t2);
        if (hav < 0)
            hav = 0;
        if (hav > longint'(UNITY))
            hav = longint'(UNITY);
        x = longint'(root_q60(UNITY - 64'(hav)));
        y = longint'(root_q60(64'(hav)));
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arctan_q60[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan_q60[i];
            end
        end
        if (z < 0)
            z = 0;
        d = scaled_product(64'(z), 64'(rad) * 100, 58);
        d = (d + 1) >> 1;
        want_cm = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s: distance_cm got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    assign pending = distance_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] d;
        if (!rst_n)
        begin
            radius_m <= 24'd6371000;
            distance_due.delete();
        end
        else
        begin
            if (cfg_we)
                radius_m <= sphere_radius_m;
            if (in_valid && in_ready)
            begin
                predict_distance(first_latitude, first_longitude, second_latitude,
                                 second_longitude, radius_m, d);
                distance_due = {distance_due, d};
            end
            if (out_valid && out_ready)
            begin
                checked++;
                if (distance_due.size() == 0)
                    report("unrequested result", distance_cm, 0);
                else
                begin
                    d = distance_due.pop_front();
                    if (distance_cm !== d)
                        report("wrong distance", distance_cm, d);
                end
            end
        end
    end

    initial
    begin
        errors  = 0;
        checked = 0;
    end

endmodule

>>> dv/haversine_distance_tb.sv
`timescale 1ns / 1ps

module haversine_distance_tb;

    localparam int LIMIT = 500000;
    localparam int LAT_MAX = 377487360;
    localparam int LON_MAX = 754974720;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic        [23:0] sphere_radius_m;
    logic               in_valid;
    logic               in_ready;
    logic signed [29:0] first_latitude;
    logic signed [30:0] first_longitude;
    logic signed [29:0] second_latitude;
    logic signed [30:0] second_longitude;
    logic               out_valid;
    logic               out_ready;
    logic        [31:0] distance_cm;

    int errors;
    int pending;
    int checked;
    int sent;
    int cycles;
    int send_idle_pct;
    int stall_pct;
    bit hold_req;
    bit holding;

    haversine_distance dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .sphere_radius_m (sphere_radius_m),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_latitude  (first_latitude),
        .first_longitude (first_longitude),
        .second_latitude (second_latitude),
        .second_longitude(second_longitude),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .distance_cm     (distance_cm)
    );

    haversine_distance_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .sphere_radius_m (sphere_radius_m),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_latitude  (first_latitude),
        .first_longitude (first_longitude),
        .second_latitude (second_latitude),
        .second_longitude(second_longitude),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .distance_cm     (distance_cm),
        .errors          (errors),
        .pending         (pending),
        .checked         (checked)
    );

    initial
        clk = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req && !holding)
        begin
            holding <= 1;
            repeat (400) @(posedge clk);
            holding <= 0;
        end
    end

    always @(posedge clk)
        if (rst_n)
            out_ready <= !holding && ($urandom_range(0, 99) >= stall_pct);

    task automatic send_request(input logic signed [29:0] lat1, input logic signed [30:0] lon1,
                                input logic signed [29:0] lat2, input logic signed [30:0] lon2);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid         <= 1;
        first_latitude   <= lat1;
        first_longitude  <= lon1;
        second_latitude  <= lat2;
        second_longitude <= lon2;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
        end
        sent++;
    endtask

    function automatic logic signed [29:0] pick_lat();
        case ($urandom_range(0, 9))
            0: return 30'($urandom);
            1: return ($urandom_range(0, 1)) ? 30'(LAT_MAX) : -30'(LAT_MAX);
            default: return 30'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        endcase
    endfunction

    function automatic logic signed [30:0] pick_lon();
        case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1: return ($urandom_range(0, 1)) ? 31'(LON_MAX) : -31'(LON_MAX);
            default: return 31'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        endcase
    endfunction

    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_radius(input logic [23:0] r);
        drain();
        cfg_we          <= 1;
        sphere_radius_m <= r;
        @(posedge clk);
        cfg_we          <= 0;
        @(posedge clk);
    endtask

    task automatic random_burst(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n)
        begin
            // near pairs exercise small angles
            if ($urandom_range(0, 3) == 0)
            begin
                logic signed [29:0] la;
                logic signed [30:0] lo;
                la = 30'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
                lo = 31'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
                send_request(la, lo, la + 30'(int'($urandom_range(0, 2000)) - 1000),
                             lo + 31'(int'($urandom_range(0, 2000)) - 1000));
            end
            else
                send_request(pick_lat(), pick_lon(), pick_lat(), pick_lon());
        end
    endtask

    initial
    begin
        rst_n            = 0;
        cfg_we           = 0;
        sphere_radius_m  = 0;
        in_valid         = 0;
        out_ready        = 0;
        first_latitude   = 0;
        first_longitude  = 0;
        second_latitude  = 0;
        second_longitude = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_req         = 0;
        holding          = 0;
        cycles           = 0;
        sent             = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed requests at the default radius
        send_request(0, 0, 0, 0);
        send_request(30'(LAT_MAX), 0, -30'(LAT_MAX), 0);
        send_request(0, 0, 0, 31'(LON_MAX));
        send_request(0, -31'(LON_MAX), 0, 31'(LON_MAX));
        send_request(0, 0, 0, 31'(LON_MAX / 2));
        send_request(30'(LAT_MAX), 31'(LON_MAX), 30'(LAT_MAX), -31'(LON_MAX));
        send_request(-30'(LAT_MAX), 123456, -30'(LAT_MAX), -987654);
        send_request(30'h2000_0000, 31'h4000_0000, 30'h1FFF_FFFF, 31'h3FFF_FFFF);
        send_request(30'h1FFF_FFFF, 31'h3FFF_FFFF, 30'h2000_0000, 31'h4000_0000);
        send_request(30'sd400000000, 0, 30'sd400000000, 31'sd100000000);
        send_request(30'sd200000000, 31'sd300000000, 30'sd200000001, 31'sd300000000);
        send_request(30'sd200000000, 31'sd300000000, 30'sd200000000, 31'sd300000000);
        send_request(-30'sd100000000, 31'sd700000000, 30'sd150000000, -31'sd700000000);
        send_request(30'h3FFF_FFFF, 31'h7FFF_FFFF, 0, 0);
        send_request(30'sd188743680, 0, -30'sd188743680, 31'sd754974720);
        send_request(0, 0, 1, 1);

        set_radius(24'd1);
        send_request(30'(LAT_MAX), 0, -30'(LAT_MAX), 0);
        random_burst(150, 0, 0);

        set_radius(24'hFF_FFFF);
        send_request(0, 0, 0, 31'(LON_MAX));
        random_burst(200, 76, 0);

        set_radius(24'd0);
        send_request(0, 0, 0, 31'(LON_MAX));
        random_burst(150, 0, 76);

        set_radius(24'd10000000);
        send_request(0, 0, 0, 31'(LON_MAX));
        random_burst(100, 0, 0);
        hold_req <= 1;
        random_burst(150, 0, 0);
        hold_req <= 0;

        set_radius(24'($urandom_range(1, 10000000)));
        random_burst(180, 9, 9);

        set_radius(24'd6371000);
        random_burst(100, 0, 0);
        drain();

        $display("%0d requests sent over radii 0 to 2^24-1 under varied idling and a long stall",
                 sent);
        $display("%0d distances compared, %0d mismatches", checked, errors);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
